### hdl/kle_pkg.sv
// ----------------------------------------------------------------------------
// kle_pkg
// Shared types and constants for the keystroke line editor: line capacity,
// store widths, key codes and the packed input and result beats.
// ----------------------------------------------------------------------------
package kle_pkg;

    // Line capacity and the widths that follow from it.
    localparam int unsigned LINE_MAX = 64;
    localparam int unsigned ADDR_W   = $clog2(LINE_MAX);
    localparam int unsigned CNT_W    = $clog2(LINE_MAX + 1);
    localparam int unsigned CHAR_W   = 8;

    localparam logic [CNT_W-1:0] LINE_CNT = CNT_W'(LINE_MAX);

    // Keystroke codes with a special meaning; every other byte is inserted if the line has room.
    localparam logic [CHAR_W-1:0] KEY_LEFT  = 8'h3C;
    localparam logic [CHAR_W-1:0] KEY_RIGHT = 8'h3E;
    localparam logic [CHAR_W-1:0] KEY_BACK  = 8'h2D;

    // Input beat.
    typedef struct packed {
        logic              func;
        logic [CHAR_W-1:0] key;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
        logic              line_empty;
        logic              overflowed;
    } t_out;

endpackage

### hdl/kle_ram.sv
// ----------------------------------------------------------------------------
// kle_ram
// One character stack store: a single write port and a single read port
// with registered read data.
// ----------------------------------------------------------------------------
module kle_ram
    import kle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [CHAR_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [CHAR_W-1:0] o_rdata
);

    logic [CHAR_W-1:0] r_mem [LINE_MAX];
    logic [CHAR_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data register holds its value when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/keystroke_line_editor_core.sv
// ----------------------------------------------------------------------------
// keystroke_line_editor_core
// Insert-mode line editor held as a gap buffer in two stack stores.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Insert, backspace,
// a dropped insert and a cursor move that cannot happen leave busy low; a
// cursor move that shifts a character holds busy in S_MOVE, because the
// character is read from one store and written into the other on the
// following cycle. A flush holds busy while the read address walks one
// character per cycle; each result passes the store read register and the
// result register, one beat per cycle on o_valid. A flush of an empty line
// gives one beat marked empty. The receiver cannot stall, so every beat
// must be taken in the cycle that it is shown.
module keystroke_line_editor_core
    import kle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_result
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MOVE  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_bc, n_bc;
    logic [CNT_W-1:0]  r_ac, n_ac;
    logic              r_drop, n_drop;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ADDR_W-1:0] r_last_idx, n_last_idx;
    logic              r_mv_right, n_mv_right;
    logic              r_rd_vld;
    logic              r_rd_after;
    logic              r_rd_last;
    logic              r_out_vld;
    t_out              r_out;

    logic              w_accept;
    logic [CNT_W:0]    w_total;
    logic              w_is_key;
    logic              w_special;
    logic              w_left, w_right, w_back, w_ins, w_drop;
    logic              w_flush, w_flush_empty, w_flush_go;
    logic              w_in_before;
    logic              w_flush_end;

    logic              bf_we, bf_re, af_we, af_re;
    logic [ADDR_W-1:0] bf_waddr, bf_raddr, af_waddr, af_raddr;
    logic [CHAR_W-1:0] bf_wdata, bf_rdata, af_wdata, af_rdata;

    // Handshake and decode of the incoming keystroke.
    assign busy     = (r_state != S_IDLE) || r_rd_vld;
    assign w_accept = start && !busy;
    assign w_total  = {1'b0, r_bc} + {1'b0, r_ac};

    assign w_is_key  = w_accept && !i_item.func;
    assign w_special = (i_item.key == KEY_LEFT) || (i_item.key == KEY_RIGHT) ||
                       (i_item.key == KEY_BACK);
    assign w_left    = w_is_key && (i_item.key == KEY_LEFT) &&
                       (r_bc != '0) && (r_ac != LINE_CNT);
    assign w_right   = w_is_key && (i_item.key == KEY_RIGHT) &&
                       (r_ac != '0) && (r_bc != LINE_CNT);
    assign w_back    = w_is_key && (i_item.key == KEY_BACK) && (r_bc != '0);
    assign w_ins     = w_is_key && !w_special && (w_total < {1'b0, LINE_CNT});
    assign w_drop    = w_is_key && !w_special && !(w_total < {1'b0, LINE_CNT});

    assign w_flush       = w_accept && i_item.func;
    assign w_flush_empty = w_flush && (w_total == '0);
    assign w_flush_go    = w_flush && (w_total != '0);

    // During a flush the left stack is read bottom up, then the right one top down.
    assign w_in_before = CNT_W'(r_idx) < r_bc;
    assign w_flush_end = (r_state == S_FLUSH) && (r_idx == r_last_idx);

    // Next-state logic for the sequencer and the stack counts.
    always_comb begin
        n_state    = r_state;
        n_bc       = r_bc;
        n_ac       = r_ac;
        n_drop     = r_drop;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        n_mv_right = r_mv_right;
        unique case (r_state)
            S_IDLE: begin
                priority if (w_left) begin
                    n_bc       = r_bc - 1'b1;
                    n_mv_right = 1'b0;
                    n_state    = S_MOVE;
                end else if (w_right) begin
                    n_ac       = r_ac - 1'b1;
                    n_mv_right = 1'b1;
                    n_state    = S_MOVE;
                end else if (w_back) begin
                    n_bc = r_bc - 1'b1;
                end else if (w_ins) begin
                    n_bc = r_bc + 1'b1;
                end else if (w_drop) begin
                    n_drop = 1'b1;
                end else if (w_flush_go) begin
                    n_idx      = '0;
                    n_last_idx = ADDR_W'(w_total - 1'b1);
                    n_state    = S_FLUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MOVE: begin
                if (r_mv_right) begin
                    n_bc = r_bc + 1'b1;
                end else begin
                    n_ac = r_ac + 1'b1;
                end
                n_state = S_IDLE;
            end
            S_FLUSH: begin
                n_idx = r_idx + 1'b1;
                if (w_flush_end) begin
                    n_bc    = '0;
                    n_ac    = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_bc       <= '0;
            r_ac       <= '0;
            r_drop     <= 1'b0;
            r_idx      <= '0;
            r_last_idx <= '0;
            r_mv_right <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_bc       <= n_bc;
            r_ac       <= n_ac;
            r_drop     <= n_drop;
            r_idx      <= n_idx;
            r_last_idx <= n_last_idx;
            r_mv_right <= n_mv_right;
            r_rd_vld   <= (r_state == S_FLUSH);
            r_out_vld  <= r_rd_vld || w_flush_empty;
        end
    end

    // Left stack store: inserts and right moves write, left moves and flushes read.
    assign bf_we    = w_ins || ((r_state == S_MOVE) && r_mv_right);
    assign bf_waddr = r_bc[ADDR_W-1:0];
    assign bf_wdata = w_ins ? i_item.key : af_rdata;
    assign bf_re    = w_left || ((r_state == S_FLUSH) && w_in_before);
    assign bf_raddr = (r_state == S_FLUSH) ? r_idx : ADDR_W'(r_bc - 1'b1);

    // Right stack store: left moves write, right moves and flushes read.
    assign af_we    = (r_state == S_MOVE) && !r_mv_right;
    assign af_waddr = r_ac[ADDR_W-1:0];
    assign af_wdata = bf_rdata;
    assign af_re    = w_right || ((r_state == S_FLUSH) && !w_in_before);
    assign af_raddr = (r_state == S_FLUSH) ? (r_last_idx - r_idx) : ADDR_W'(r_ac - 1'b1);

    kle_ram u_before (
        .i_clk   (i_clk),
        .i_we    (bf_we),
        .i_waddr (bf_waddr),
        .i_wdata (bf_wdata),
        .i_re    (bf_re),
        .i_raddr (bf_raddr),
        .o_rdata (bf_rdata)
    );

    kle_ram u_after (
        .i_clk   (i_clk),
        .i_we    (af_we),
        .i_waddr (af_waddr),
        .i_wdata (af_wdata),
        .i_re    (af_re),
        .i_raddr (af_raddr),
        .o_rdata (af_rdata)
    );

    // Tags that travel alongside each flush read.
    always_ff @(posedge i_clk) begin
        r_rd_after <= !w_in_before;
        r_rd_last  <= w_flush_end;
    end

    // Result register: a character from the stores or the empty-line beat.
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_out.out_char   <= r_rd_after ? af_rdata : bf_rdata;
            r_out.last       <= r_rd_last;
            r_out.line_empty <= 1'b0;
            r_out.overflowed <= r_drop;
        end else begin
            r_out.out_char   <= '0;
            r_out.last       <= 1'b1;
            r_out.line_empty <= 1'b1;
            r_out.overflowed <= r_drop;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // The two stacks never hold more than a full line between them.
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_bc} + {1'b0, r_ac}) <= {1'b0, LINE_CNT})
        else $error("gap buffer holds more than a full line");

    // A character move completes in the cycle after it was accepted.
    a_move_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |=> (r_state == S_IDLE))
        else $error("character move did not finish in one cycle");

    // Issuing the final flush read empties both stacks.
    a_flush_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_flush_end |=> ((r_bc == '0) && (r_ac == '0)))
        else $error("stacks not cleared after flush");

    // No new item may enter while a flush read is still in flight.
    a_rd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> busy)
        else $error("item accepted with a flush read in flight");

    // Every flush read whose data has left the store turns into a result beat on the next cycle.
    a_rd_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |=> o_valid)
        else $error("flush read did not produce a result beat");

endmodule
